// ----- rtl/pote_pkg.sv -----
// Shared types and character codes for the printer output tab expander.
package pote_pkg;

    localparam int CHAR_W = 8;
    localparam int COL_W  = 3;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(7);

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;   // latch a new input character
        logic step;   // current output byte transferred, advance
    } dp_cmd_t;

    typedef struct packed {
        logic last;   // current output byte is the final one for this input
    } dp_status_t;

endpackage

// ----- rtl/pote_ctrl.sv -----
// Controller: accepts one character, then sequences its output bytes.
module pote_ctrl
    import pote_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.step = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/pote_dp.sv -----
// Datapath: mode register, column tracker, output byte and remaining count.
module pote_dp
    import pote_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic [CHAR_W-1:0] in_char,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    output logic [CHAR_W-1:0] out_char
);

    logic              raw_reg;
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] out_reg,  out_next;
    logic [COL_W-1:0]  rem_reg,  rem_next;   // bytes left after the current one

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg <= 1'b0;
            col_reg <= '0;
        end else begin
            if (cfg_valid) begin
                raw_reg <= cfg_data;
            end
            col_reg <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            char_reg <= in_char;
        end
        out_reg <= out_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        col_next = col_reg;
        out_next = out_reg;
        rem_next = rem_reg;
        if (cmd.load) begin
            out_next = in_char;
            rem_next = '0;
            if (!raw_reg) begin
                case (in_char)
                    CH_TAB: begin
                        // spaces up to the next tab stop
                        out_next = CH_SPACE;
                        rem_next = COL_MAX - col_reg;
                        col_next = '0;
                    end
                    CH_LF: begin
                        out_next = CH_CR;
                        rem_next = COL_W'(1);
                        col_next = '0;
                    end
                    CH_BS: begin
                        col_next = col_reg - COL_W'(1);
                    end
                    default: begin
                        if (in_char inside {CH_CR, CH_FF}) begin
                            col_next = '0;
                        end else begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                endcase
            end
        end else if (cmd.step && (rem_reg != '0)) begin
            rem_next = rem_reg - COL_W'(1);
            // tabs keep sending spaces; a newline follows its CR
            if (char_reg != CH_TAB) begin
                out_next = char_reg;
            end
        end
    end

    assign status.last = (rem_reg == '0);
    assign out_char    = out_reg;

endmodule

// ----- rtl/printer_output_tab_expander.sv -----
// Top level of the printer output tab expander.
// Takes one character byte per input transfer and sends the bytes for the printer, one per
// output transfer, with tlast on the final byte of each input. Cooked mode expands a tab into
// 1 to 8 spaces up to the next multiple-of-8 column and sends CR before a newline; raw mode
// (cfg_data = 1) passes every byte unchanged. A new character is taken only when the final
// byte of the last one has gone; bytes leave the output register one a cycle while m_tready
// is high. The mode register is written through the cfg channel, which is always ready; the
// user must write it only while the block is idle, as the block itself does not enforce it.
module printer_output_tab_expander
    import pote_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,    // [0] raw_mode
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,     // [7:0] in_char
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,     // [7:0] out_char
    output logic              m_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;
    assign m_tlast   = status.last;

    pote_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pote_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_char   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_char  (m_tdata)
    );

endmodule
